FILE: design/e2e_frame_checker_defines.svh
//----------------------------------------------------------------------------
// E2E frame checker assertion macros
// Concurrent assertion wrappers shared by the checker modules. They compile
// to nothing when SYNTHESIS is defined.
//----------------------------------------------------------------------------
`ifndef E2E_FRAME_CHECKER_DEFINES_SVH
`define E2E_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define E2E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("e2e frame checker assertion failed");

// condition that must never be seen outside reset
`define E2E_ASSERT_NEVER(lbl, cond) \
  `E2E_ASSERT(lbl, !(cond))

`else

`define E2E_ASSERT(lbl, prop)
`define E2E_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: design/e2e_pkg.sv
//----------------------------------------------------------------------------
// E2E frame checker package
// Shared types, header layout, verdict codes and the byte-wide CRC update.
//----------------------------------------------------------------------------
package e2e_pkg;

  // header layout: byte positions within a frame
  localparam int POS_W = 4;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_DID_LO  = 4'd0;
  localparam pos_t POS_DID_HI  = 4'd1;
  localparam pos_t POS_SID_LO  = 4'd2;
  localparam pos_t POS_SID_HI  = 4'd3;
  localparam pos_t POS_SEQ0    = 4'd4;
  localparam pos_t POS_SEQ3    = 4'd7;
  localparam pos_t POS_CRC_LO  = 4'd8;
  localparam pos_t POS_CRC_HI  = 4'd9;
  localparam pos_t POS_PAYLOAD = 4'd10;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // configuration register indexes (decoded from paddr[2])
  localparam logic REG_DATA_ID   = 1'b0;
  localparam logic REG_SOURCE_ID = 1'b1;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_CRC   = 2'd2,
    VERDICT_GAP   = 2'd3
  } verdict_t;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    pos_t       pos;
  } item_t;

  // one result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    verdict_t    verdict;
    logic [31:0] sequence_seen;
    logic [31:0] sequence_expected;
  } result_t;

  // one byte through the CRC, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/e2e_frame_checker.sv
//----------------------------------------------------------------------------
// E2E frame checker
// Receive-side check of end-to-end protected frames (CRC-16/CCITT-FALSE
// over the configured ids, sequence bytes and payload, plus sequence check).
//----------------------------------------------------------------------------
// Usage:
//   The s_ stream carries one frame byte per word, s_tlast on the final
//   byte. Every input word gives exactly one m_ word: m_tuser flags payload
//   bytes (position ten and on), m_tlast marks the frame's end, where the
//   verdict (ok, short header, CRC mismatch, sequence gap) and the
//   sequence numbers are valid.
//   Throughput is one word per cycle, set by the byte-wide CRC update in
//   the back end, while m_tready is high. The front end tags an accepted
//   word into the queue, then the back end loads the output register.
//   The APB port sets data_identifier (0x0) and source_identifier (0x4);
//   write them only while no frame is in flight.
//   Reset (rst, synchronous) empties the queue, drops the output word,
//   restarts the frame and forgets the last accepted sequence number.
//   When the receiver holds m_tready low the result word waits in the
//   output register and the four-word queue absorbs input until it fills,
//   then s_tready falls.
//----------------------------------------------------------------------------
module e2e_frame_checker (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] payload_byte, [9:8] verdict,
                                 // [41:10] sequence_seen,
                                 // [73:42] sequence_expected, [79:74] zero
  output logic        m_tuser,   // payload_valid
  output logic        m_tlast,   // frame_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]       data_identifier;
  logic [15:0]       source_identifier;
  logic              cfg_write;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  e2e_pkg::item_t    push_item;
  e2e_pkg::item_t    head;
  e2e_pkg::result_t  result;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_identifier   <= '0;
      source_identifier <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        e2e_pkg::REG_DATA_ID:   data_identifier   <= pwdata[15:0];
        e2e_pkg::REG_SOURCE_ID: source_identifier <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      e2e_pkg::REG_DATA_ID:   prdata = {16'h0000, data_identifier};
      e2e_pkg::REG_SOURCE_ID: prdata = {16'h0000, source_identifier};
      default:                prdata = '0;
    endcase
  end

  e2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  e2e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  e2e_back u_back (
    .clk               (clk),
    .rst               (rst),
    .data_identifier   (data_identifier),
    .source_identifier (source_identifier),
    .empty             (q_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .result            (result)
  );

  // pack the result word
  assign m_tuser = result.payload_valid;
  assign m_tlast = result.frame_done;
  assign m_tdata = {6'b000000, result.sequence_expected, result.sequence_seen,
                    result.verdict, result.payload_byte};

endmodule

FILE: design/e2e_front.sv
//----------------------------------------------------------------------------
// E2E frame checker front end
// Accepts input words, tracks the byte position in the frame and tags each
// word with it before pushing it into the queue.
//----------------------------------------------------------------------------
module e2e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] frame_byte
  input  logic            s_tlast,   // last_byte
  input  logic            q_full,
  output logic            push,
  output e2e_pkg::item_t  push_item
);

  e2e_pkg::pos_t pos;
  e2e_pkg::pos_t pos_next;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // tag the word with its position, saturating at the payload code
  always_comb begin
    push_item.data = s_tdata;
    push_item.last = s_tlast;
    push_item.pos  = pos;
    if (s_tlast) begin
      pos_next = e2e_pkg::POS_DID_LO;
    end else if (pos == e2e_pkg::POS_PAYLOAD) begin
      pos_next = pos;
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= e2e_pkg::POS_DID_LO;
    end else if (push) begin
      pos <= pos_next;
    end
  end

endmodule

FILE: design/e2e_queue.sv
//----------------------------------------------------------------------------
// E2E frame checker queue
// Short FIFO of classified words between the front end and the back end.
//----------------------------------------------------------------------------
`include "e2e_frame_checker_defines.svh"

module e2e_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  e2e_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output e2e_pkg::item_t  head,
  output logic            empty
);

  e2e_pkg::item_t                      slots [e2e_pkg::QUEUE_DEPTH];
  logic [e2e_pkg::QUEUE_AW-1:0]        wr_ptr;
  logic [e2e_pkg::QUEUE_AW-1:0]        rd_ptr;
  logic [e2e_pkg::QUEUE_CW-1:0]        count;

  assign full  = count == e2e_pkg::QUEUE_CW'(e2e_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `E2E_ASSERT_NEVER(a_push_when_full, push && full)
  `E2E_ASSERT_NEVER(a_pop_when_empty, pop && empty)
  `E2E_ASSERT(a_count_grows, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule

FILE: design/e2e_back.sv
//----------------------------------------------------------------------------
// E2E frame checker back end
// Pops classified words, runs the CRC and sequence checks and holds the
// result word in the output register.
//----------------------------------------------------------------------------
`include "e2e_frame_checker_defines.svh"

module e2e_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       data_identifier,
  input  logic [15:0]       source_identifier,
  input  logic              empty,
  input  e2e_pkg::item_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output e2e_pkg::result_t  result
);

  logic [15:0]         crc;
  logic [15:0]         crc_next;
  logic [31:0]         frame_seq;
  logic [31:0]         frame_seq_next;
  logic [15:0]         carried;
  logic [15:0]         carried_next;
  logic                have_prev;
  logic [31:0]         prev_seq;
  logic [31:0]         prev_plus1;
  logic [7:0]          crc_in;
  logic                crc_en;
  logic                is_payload;
  logic [1:0]          seq_lane;
  logic                hdr_short;
  logic                crc_bad;
  logic                seq_gap;
  logic                record;
  e2e_pkg::result_t    result_next;

  // advance when a word is waiting and the output register is free
  assign pop = !empty && (!out_valid || out_ready);

  assign seq_lane = 2'(head.pos - e2e_pkg::POS_SEQ0);

  // per-position decode of the header
  always_comb begin
    crc_in         = head.data;
    crc_en         = 1'b0;
    is_payload     = 1'b0;
    frame_seq_next = frame_seq;
    carried_next   = carried;
    unique case (head.pos) inside
      e2e_pkg::POS_DID_LO: begin
        crc_in = data_identifier[7:0];
        crc_en = 1'b1;
      end
      e2e_pkg::POS_DID_HI: begin
        crc_in = data_identifier[15:8];
        crc_en = 1'b1;
      end
      e2e_pkg::POS_SID_LO: begin
        crc_in = source_identifier[7:0];
        crc_en = 1'b1;
      end
      e2e_pkg::POS_SID_HI: begin
        crc_in = source_identifier[15:8];
        crc_en = 1'b1;
      end
      [e2e_pkg::POS_SEQ0:e2e_pkg::POS_SEQ3]: begin
        frame_seq_next[seq_lane*8 +: 8] = head.data;
        crc_en = 1'b1;
      end
      e2e_pkg::POS_CRC_LO: begin
        carried_next[7:0] = head.data;
      end
      e2e_pkg::POS_CRC_HI: begin
        carried_next[15:8] = head.data;
      end
      default: begin
        crc_en     = 1'b1;
        is_payload = 1'b1;
      end
    endcase
    crc_next = crc_en ? e2e_pkg::crc16_byte(crc, crc_in) : crc;
  end

  // end-of-frame checks, in order of precedence
  always_comb begin
    prev_plus1 = prev_seq + 32'd1;
    hdr_short  = head.pos < e2e_pkg::POS_CRC_HI;
    crc_bad    = crc_next != carried_next;
    seq_gap    = have_prev && (frame_seq != prev_plus1);
    record     = head.last && !hdr_short && !crc_bad;

    result_next.payload_valid     = is_payload;
    result_next.payload_byte      = is_payload ? head.data : 8'h00;
    result_next.frame_done        = head.last;
    result_next.verdict           = e2e_pkg::VERDICT_OK;
    result_next.sequence_seen     = '0;
    result_next.sequence_expected = '0;
    if (head.last) begin
      if (hdr_short) begin
        result_next.verdict = e2e_pkg::VERDICT_SHORT;
      end else begin
        result_next.sequence_seen = frame_seq;
        if (crc_bad) begin
          result_next.verdict = e2e_pkg::VERDICT_CRC;
        end else if (seq_gap) begin
          result_next.verdict           = e2e_pkg::VERDICT_GAP;
          result_next.sequence_expected = prev_plus1;
        end
      end
    end
  end

  // frame and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= e2e_pkg::CRC_INIT;
      frame_seq <= '0;
      carried   <= '0;
      have_prev <= 1'b0;
      prev_seq  <= '0;
    end else if (pop) begin
      if (head.last) begin
        crc       <= e2e_pkg::CRC_INIT;
        frame_seq <= '0;
        carried   <= '0;
      end else begin
        crc       <= crc_next;
        frame_seq <= frame_seq_next;
        carried   <= carried_next;
      end
      if (record) begin
        have_prev <= 1'b1;
        prev_seq  <= frame_seq;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  `E2E_ASSERT(a_clear_after_last, (pop && head.last) |=> (crc == e2e_pkg::CRC_INIT && frame_seq == '0 && carried == '0))
  `E2E_ASSERT_NEVER(a_prev_kept, $fell(have_prev))
  `E2E_ASSERT(a_held_result, (out_valid && !out_ready) |=> $stable(result))

endmodule
